[hw/rtl/nfr_pkg.sv]
// Shared types and constants of the NAT flow rewriter.
// Used by every module of the block; depends on nothing.
package nfr_pkg;

  // Address/port four-tuple, as stored for keys and rewrites
  typedef struct packed {
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
  } tuple_t;

  // One flow table entry
  typedef struct packed {
    logic   vld;
    tuple_t key;
    tuple_t act;
  } entry_t;

  // Flags collected by one table scan
  typedef struct packed {
    logic hit;
    logic rev_hit;
    logic free1;
    logic free2;
  } match_flags_t;

  typedef enum logic [1:0] {
    VERDICT_DROP  = 2'd0,
    VERDICT_FWD   = 2'd1,
    VERDICT_UNMOD = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WR1,
    ST_WR2,
    ST_EMIT
  } state_e;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_PATTERN_EN = 3'd0;
  localparam logic [2:0] REG_NEW_SRC    = 3'd1;
  localparam logic [2:0] REG_NEW_DST    = 3'd2;
  localparam logic [2:0] REG_PORT_BASE  = 3'd3;
  localparam logic [2:0] REG_NEW_DPORT  = 3'd4;
  localparam logic [2:0] REG_PORT_RANGE = 3'd5;
  localparam logic [2:0] REG_EXH_COUNT  = 3'd6;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

endpackage

[hw/rtl/nfr_table.sv]
// Flow table memory: one write port, one read port with registered data.
// Depends on nfr_pkg for the entry layout.
module nfr_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  nfr_pkg::entry_t     wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output nfr_pkg::entry_t     rdata_o
);

  nfr_pkg::entry_t mem_q [DEPTH];
  nfr_pkg::entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/nfr_match.sv]
// Shared compare unit: checks one table entry per cycle while chk_i is high
// against the key and the reverse key and records the first match and the two
// lowest free slots. Depends on nfr_pkg.
module nfr_match #(
  parameter int AW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  chk_i,
  input  logic [AW-1:0]         idx_i,
  input  nfr_pkg::entry_t       entry_i,
  input  nfr_pkg::tuple_t       key_i,
  input  nfr_pkg::tuple_t       rev_i,
  output nfr_pkg::match_flags_t flags_o,
  output logic [AW-1:0]         rev_idx_o,
  output logic [AW-1:0]         free1_idx_o,
  output logic [AW-1:0]         free2_idx_o,
  output nfr_pkg::tuple_t       act_o
);

  nfr_pkg::match_flags_t flags_q, flags_d;
  logic [AW-1:0]         rev_idx_q, free1_idx_q, free2_idx_q;
  nfr_pkg::tuple_t       act_q;
  logic                  key_m, rev_m;

  assign key_m = entry_i.vld && (entry_i.key == key_i);
  assign rev_m = entry_i.vld && (entry_i.key == rev_i);

  // Update the found flags for the entry under check
  always_comb begin
    flags_d = flags_q;
    if (start_i) begin
      flags_d = '0;
    end else if (chk_i) begin
      if (key_m) flags_d.hit = 1'b1;
      if (rev_m) flags_d.rev_hit = 1'b1;
      if (!entry_i.vld) begin
        if (!flags_q.free1) flags_d.free1 = 1'b1;
        else                flags_d.free2 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // Capture the slot indexes and the hit rewrite on first find
  always_ff @(posedge clk_i) begin
    if (chk_i && !start_i) begin
      if (key_m && !flags_q.hit) act_q <= entry_i.act;
      if (rev_m && !flags_q.rev_hit) rev_idx_q <= idx_i;
      if (!entry_i.vld && !flags_q.free1) free1_idx_q <= idx_i;
      if (!entry_i.vld && flags_q.free1 && !flags_q.free2) free2_idx_q <= idx_i;
    end
  end

  assign flags_o     = flags_q;
  assign rev_idx_o   = rev_idx_q;
  assign free1_idx_o = free1_idx_q;
  assign free2_idx_o = free2_idx_q;
  assign act_o       = act_q;

endmodule

[hw/rtl/nat_flow_rewriter_core.sv]
// NAT flow rewriter top level: stream channels, register port, sequencer.
// Depends on nfr_pkg, nfr_table and nfr_match.
//
// Usage:
//   One IPv4 header plus transport ports enter per transaction on the s_axis
//   channel; one verdict with rewritten addresses, ports and header checksum
//   leaves per transaction on the m_axis channel. Registers are to be written
//   over the APB port only while the block is idle; the block itself does not
//   enforce this. The port-exhaustion drop counter reads at index 6. A packet
//   that fails the protocol/fragment/transport_ok filter goes straight to its
//   result. Any other packet scans the whole flow table through one compare
//   unit fed by the single read port, then may write forward and reverse entries.
//   s_axis_tready is high only while the sequencer is idle, so one packet is
//   in work at a time. The result sits in an output register; a stalled
//   receiver holds it and the next packet is taken meanwhile, but that packet
//   waits at its end until the register is free.
//   After reset a clearing pass marks every table entry empty; no packet is taken
//   during it, register writes are taken as ever.
module nat_flow_rewriter_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // ver_ihl_tos, total_length, ident, flags_fragment, ttl_protocol,
  // src_addr, dst_addr, src_port, dst_port
  input  logic [175:0]  s_axis_tdata,
  input  logic [0:0]    s_axis_tuser,   // transport_ok
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // out_src_addr, out_dst_addr, out_src_port, out_dst_port, out_checksum
  output logic [111:0]  m_axis_tdata,
  output logic [2:0]    m_axis_tuser,   // verdict[1:0], table_hit
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);

  // Configuration registers
  logic        pen_q;
  logic [31:0] new_src_q, new_dst_q;
  logic [15:0] port_base_q, new_dport_q, port_range_q;
  logic [31:0] exh_q, exh_d;
  logic [16:0] off_q, off_d;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q        <= 1'b0;
      new_src_q    <= '0;
      new_dst_q    <= '0;
      port_base_q  <= '0;
      new_dport_q  <= '0;
      port_range_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        nfr_pkg::REG_PATTERN_EN: pen_q        <= pwdata[0];
        nfr_pkg::REG_NEW_SRC:    new_src_q    <= pwdata;
        nfr_pkg::REG_NEW_DST:    new_dst_q    <= pwdata;
        nfr_pkg::REG_PORT_BASE:  port_base_q  <= pwdata[15:0];
        nfr_pkg::REG_NEW_DPORT:  new_dport_q  <= pwdata[15:0];
        nfr_pkg::REG_PORT_RANGE: port_range_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:2])
      nfr_pkg::REG_PATTERN_EN: prdata = {31'd0, pen_q};
      nfr_pkg::REG_NEW_SRC:    prdata = new_src_q;
      nfr_pkg::REG_NEW_DST:    prdata = new_dst_q;
      nfr_pkg::REG_PORT_BASE:  prdata = {16'd0, port_base_q};
      nfr_pkg::REG_NEW_DPORT:  prdata = {16'd0, new_dport_q};
      nfr_pkg::REG_PORT_RANGE: prdata = {16'd0, port_range_q};
      nfr_pkg::REG_EXH_COUNT:  prdata = exh_q;
      default:                 prdata = '0;
    endcase
  end

  // Header checksum over the 20-byte header with the given addresses
  function automatic logic [15:0] hdr_csum(input logic [79:0] w, input logic [31:0] sa,
                                           input logic [31:0] da);
    logic [19:0] s;
    logic [16:0] f;
    s = 20'(w[15:0]) + 20'(w[31:16]) + 20'(w[47:32]) + 20'(w[63:48]) + 20'(w[79:64])
      + 20'(sa[31:16]) + 20'(sa[15:0]) + 20'(da[31:16]) + 20'(da[15:0]);
    f = 17'(s[15:0]) + 17'(s[19:16]);
    f = 17'(f[15:0]) + 17'(f[16]);
    return ~f[15:0];
  endfunction

  // Input unpacking and the new-flow rewrite
  nfr_pkg::tuple_t in_key, in_rw, in_rev, in_back;
  logic            in_pass;

  assign in_key.sa = s_axis_tdata[111:80];
  assign in_key.da = s_axis_tdata[143:112];
  assign in_key.sp = s_axis_tdata[159:144];
  assign in_key.dp = s_axis_tdata[175:160];

  assign in_pass = ((s_axis_tdata[71:64] == nfr_pkg::PROTO_TCP) ||
                    (s_axis_tdata[71:64] == nfr_pkg::PROTO_UDP)) &&
                   (s_axis_tdata[60:48] == 13'd0) && s_axis_tuser[0];

  assign in_rw.sa = (new_src_q != '0) ? new_src_q : in_key.sa;
  assign in_rw.da = (new_dst_q != '0) ? new_dst_q : in_key.da;
  assign in_rw.dp = (new_dport_q != '0) ? new_dport_q : in_key.dp;
  assign in_rw.sp = port_base_q + off_q[15:0];

  assign in_rev  = '{sa: in_rw.da, da: in_rw.sa, sp: in_rw.dp, dp: in_rw.sp};
  assign in_back = '{sa: in_key.da, da: in_key.sa, sp: in_key.dp, dp: in_key.sp};

  // Sequencer state
  nfr_pkg::state_e   state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              chk_vld_q;
  logic [AW-1:0]     chk_idx_q;
  logic              s_acc;

  assign s_axis_tready = (state_q == nfr_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Packet context, loaded on accept
  logic [79:0]       hdr_q;
  nfr_pkg::tuple_t   key_q, rw_q, rev_q, back_q;
  logic              same_q;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      hdr_q  <= s_axis_tdata[79:0];
      key_q  <= in_key;
      rw_q   <= in_rw;
      rev_q  <= in_rev;
      back_q <= in_back;
      same_q <= (in_rev == in_key);
    end
  end

  // Table and compare unit
  logic                  tbl_we;
  logic [AW-1:0]         tbl_waddr;
  nfr_pkg::entry_t       tbl_wdata, tbl_rdata;
  nfr_pkg::match_flags_t mflags;
  logic [AW-1:0]         rev_idx, free1_idx, free2_idx, rslot;
  nfr_pkg::tuple_t       hit_act;

  nfr_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  nfr_match #(.AW(AW)) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_acc),
    .chk_i       (chk_vld_q),
    .idx_i       (chk_idx_q),
    .entry_i     (tbl_rdata),
    .key_i       (key_q),
    .rev_i       (rev_q),
    .flags_o     (mflags),
    .rev_idx_o   (rev_idx),
    .free1_idx_o (free1_idx),
    .free2_idx_o (free2_idx),
    .act_o       (hit_act)
  );

  assign rslot = mflags.rev_hit ? rev_idx : free2_idx;

  // Result registers
  nfr_pkg::verdict_e verdict_q, verdict_d;
  logic              hit_q, hit_d;
  nfr_pkg::tuple_t   res_q, res_d;
  logic              ovld_q;
  logic              out_load;
  logic [111:0]      out_data_q;
  logic [2:0]        out_user_q;

  // Next state, table writes and result selection
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    off_d     = off_q;
    exh_d     = exh_q;
    verdict_d = verdict_q;
    hit_d     = hit_q;
    res_d     = res_q;
    tbl_we    = 1'b0;
    tbl_waddr = free1_idx;
    tbl_wdata = '{vld: 1'b1, key: key_q, act: rw_q};
    out_load  = 1'b0;
    case (state_q)
      nfr_pkg::ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = cnt_q[AW-1:0];
        tbl_wdata = '0;
        if (cnt_q == LAST_C) begin
          cnt_d   = '0;
          state_d = nfr_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      nfr_pkg::ST_IDLE: begin
        if (s_acc) begin
          cnt_d     = '0;
          verdict_d = nfr_pkg::VERDICT_DROP;
          hit_d     = 1'b0;
          res_d     = '0;
          state_d   = in_pass ? nfr_pkg::ST_SCAN : nfr_pkg::ST_EMIT;
        end
      end
      nfr_pkg::ST_SCAN: begin
        // Issue reads until every entry is out, finish after the last check
        if (cnt_q != DEPTH_C) begin
          cnt_d = cnt_q + CW'(1);
        end else if (!chk_vld_q) begin
          cnt_d   = '0;
          state_d = nfr_pkg::ST_DECIDE;
        end
      end
      nfr_pkg::ST_DECIDE: begin
        state_d = nfr_pkg::ST_EMIT;
        if (mflags.hit) begin
          verdict_d = nfr_pkg::VERDICT_FWD;
          hit_d     = 1'b1;
          res_d     = hit_act;
        end else if (!pen_q) begin
          verdict_d = nfr_pkg::VERDICT_DROP;
        end else if (off_q > {1'b0, port_range_q}) begin
          exh_d = exh_q + 32'd1;
        end else begin
          off_d = off_q + 17'd1;
          if (mflags.free1 && (same_q || mflags.rev_hit || mflags.free2)) begin
            verdict_d = nfr_pkg::VERDICT_FWD;
            res_d     = rw_q;
            state_d   = nfr_pkg::ST_WR1;
          end else begin
            verdict_d = nfr_pkg::VERDICT_UNMOD;
            res_d     = key_q;
          end
        end
      end
      nfr_pkg::ST_WR1: begin
        tbl_we    = 1'b1;
        tbl_waddr = free1_idx;
        if (same_q) begin
          tbl_wdata = '{vld: 1'b1, key: rev_q, act: back_q};
          state_d   = nfr_pkg::ST_EMIT;
        end else begin
          state_d = nfr_pkg::ST_WR2;
        end
      end
      nfr_pkg::ST_WR2: begin
        tbl_we    = 1'b1;
        tbl_waddr = rslot;
        tbl_wdata = '{vld: 1'b1, key: rev_q, act: back_q};
        state_d   = nfr_pkg::ST_EMIT;
      end
      nfr_pkg::ST_EMIT: begin
        if (!ovld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = nfr_pkg::ST_IDLE;
        end
      end
      default: state_d = nfr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nfr_pkg::ST_CLEAR;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      off_q     <= '0;
      exh_q     <= '0;
      verdict_q <= nfr_pkg::VERDICT_DROP;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= (state_q == nfr_pkg::ST_SCAN) && (cnt_q != DEPTH_C);
      off_q     <= off_d;
      exh_q     <= exh_d;
      verdict_q <= verdict_d;
      hit_q     <= hit_d;
    end
  end

  // Track the index of the entry whose read data arrives next cycle
  always_ff @(posedge clk_i) begin
    chk_idx_q <= cnt_q[AW-1:0];
    res_q     <= res_d;
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (out_load) begin
      ovld_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {(verdict_q == nfr_pkg::VERDICT_DROP) ? 16'd0
                                                          : hdr_csum(hdr_q, res_q.sa, res_q.da),
                     res_q.dp, res_q.sp, res_q.da, res_q.sa};
      out_user_q <= {hit_q, verdict_q};
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Checks
  a_wr2_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nfr_pkg::ST_WR2) |-> (rslot != free1_idx))
    else $error("reverse entry would overwrite forward entry");

  a_exh_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(exh_q) |-> (exh_q == $past(exh_q) + 32'd1))
    else $error("drop counter moved by more than one");

  a_hit_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == nfr_pkg::VERDICT_FWD))
    else $error("table hit without forward verdict");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nfr_pkg::ST_SCAN) |=> !$past(s_acc))
    else $error("packet taken during scan");

endmodule
